// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the extent allocator.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge
`define FFEA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define FFEA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFEA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ffea_pkg.sv -----
// Package of the first-fit extent allocator: item types, codes and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package ffea_pkg;

  localparam int MAX_EXTENTS_DEF = 16;
  localparam int ADDR_BITS_DEF   = 10;

  localparam int SIZE_W       = 11;
  localparam int FIELD_ADDR_W = 10;
  localparam int STATUS_W     = 2;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam logic [SIZE_W-1:0] REGION_RESET = 11'd1000;

  localparam logic OP_ALLOC = 1'b0;

  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;

  // register index as decoded from paddr[2]
  localparam logic REG_REGION_SIZE = 1'b0;

  // write-port selects
  localparam logic [3:0] WR_NONE       = 4'd0;
  localparam logic [3:0] WR_INIT       = 4'd1;
  localparam logic [3:0] WR_SHRINK     = 4'd2;
  localparam logic [3:0] WR_SHIFT_DN   = 4'd3;
  localparam logic [3:0] WR_MERGE_BOTH = 4'd4;
  localparam logic [3:0] WR_MERGE_PREV = 4'd5;
  localparam logic [3:0] WR_MERGE_NEXT = 4'd6;
  localparam logic [3:0] WR_SHIFT_UP   = 4'd7;
  localparam logic [3:0] WR_INSERT     = 4'd8;

  // scan pointer operations
  localparam logic [2:0] PTR_HOLD = 3'd0;
  localparam logic [2:0] PTR_CLR  = 3'd1;
  localparam logic [2:0] PTR_INC  = 3'd2;
  localparam logic [2:0] PTR_DEC  = 3'd3;
  localparam logic [2:0] PTR_TOP  = 3'd4;

  // extent count operations
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  typedef struct packed {
    logic                    op;
    logic [SIZE_W-1:0]       block_size;
    logic [FIELD_ADDR_W-1:0] release_addr;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_ADDR_W-1:0] granted_addr;
    logic [STATUS_W-1:0]     status;
  } out_item_t;

  typedef struct packed {
    logic                req_load;
    logic                rd_en;
    logic                rd_up;
    logic [2:0]          ptr_op;
    logic [3:0]          wr_sel;
    logic [1:0]          cnt_op;
    logic                prev_load;
    logic                pos_load;
    logic                res_load;
    logic                res_grant;
    logic [STATUS_W-1:0] res_status;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic in_alloc;
    logic in_size_zero;
    logic count_zero;
    logic rd_vld;
    logic fwd_more;
    logic up_more;
    logic fits;
    logic exact;
    logic above;
    logic join_prev;
    logic join_next;
    logic full;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/ffea_ctrl.sv -----
// Controller of the extent allocator: sequences scan, shift, merge and
// insert steps. Depends on ffea_pkg for cmd_t, stat_t and codes.
`default_nettype none

module ffea_ctrl import ffea_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_wr,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ASCAN = 3'd2;
  localparam logic [2:0] S_RSCAN = 3'd3;
  localparam logic [2:0] S_SHDN  = 3'd4;
  localparam logic [2:0] S_SHUP  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0] state, state_next;

  assign req_ready = (state == S_IDLE) && !cfg_wr;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.wr_sel = WR_INIT;
        cmd.ptr_op = PTR_CLR;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_ready && req_valid) begin
          cmd.req_load = 1'b1;
          if (stat.in_alloc) begin
            if (stat.in_size_zero || stat.count_zero) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_NO_FIT;
              state_next     = S_RESP;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.ptr_op = PTR_INC;
              state_next = S_ASCAN;
            end
          end else if (stat.in_size_zero) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_DONE;
            state_next     = S_RESP;
          end else begin
            cmd.rd_en  = !stat.count_zero;
            cmd.ptr_op = stat.count_zero ? PTR_HOLD : PTR_INC;
            state_next = S_RSCAN;
          end
        end
      end
      S_ASCAN: begin
        if (!stat.rd_vld) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NO_FIT;
          state_next     = S_RESP;
        end else if (stat.fits) begin
          cmd.res_load   = 1'b1;
          cmd.res_grant  = 1'b1;
          cmd.res_status = ST_DONE;
          if (stat.exact) begin
            cmd.rd_en  = stat.fwd_more;
            cmd.ptr_op = stat.fwd_more ? PTR_INC : PTR_HOLD;
            state_next = S_SHDN;
          end else begin
            cmd.wr_sel = WR_SHRINK;
            state_next = S_RESP;
          end
        end else begin
          cmd.rd_en  = stat.fwd_more;
          cmd.ptr_op = stat.fwd_more ? PTR_INC : PTR_HOLD;
        end
      end
      S_RSCAN: begin
        if (stat.rd_vld && !stat.above) begin
          cmd.prev_load = 1'b1;
          cmd.rd_en     = stat.fwd_more;
          cmd.ptr_op    = stat.fwd_more ? PTR_INC : PTR_HOLD;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_DONE;
          if (stat.join_prev && stat.join_next) begin
            cmd.wr_sel = WR_MERGE_BOTH;
            cmd.rd_en  = stat.fwd_more;
            cmd.ptr_op = stat.fwd_more ? PTR_INC : PTR_HOLD;
            state_next = S_SHDN;
          end else if (stat.join_prev) begin
            cmd.wr_sel = WR_MERGE_PREV;
            state_next = S_RESP;
          end else if (stat.join_next) begin
            cmd.wr_sel = WR_MERGE_NEXT;
            state_next = S_RESP;
          end else if (stat.full) begin
            cmd.res_status = ST_TABLE_FULL;
            state_next     = S_RESP;
          end else begin
            cmd.pos_load = 1'b1;
            cmd.ptr_op   = PTR_TOP;
            state_next   = S_SHUP;
          end
        end
      end
      S_SHDN: begin
        cmd.rd_en  = stat.fwd_more;
        cmd.ptr_op = stat.fwd_more ? PTR_INC : PTR_HOLD;
        if (stat.rd_vld) begin
          cmd.wr_sel = WR_SHIFT_DN;
        end else if (!stat.fwd_more) begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_RESP;
        end
      end
      S_SHUP: begin
        cmd.rd_up  = 1'b1;
        cmd.rd_en  = stat.up_more;
        cmd.ptr_op = stat.up_more ? PTR_DEC : PTR_HOLD;
        if (stat.rd_vld) begin
          cmd.wr_sel = WR_SHIFT_UP;
        end else if (!stat.up_more) begin
          cmd.wr_sel = WR_INSERT;
          cmd.cnt_op = CNT_INC;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.ptr_op   = PTR_CLR;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
    if (cfg_wr) begin
      state_next = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ffea_dpath.sv -----
// Datapath of the extent allocator: extent memory, scan pointer, request,
// neighbour and result registers, output register. Depends on ffea_pkg.
`default_nettype none

module ffea_dpath import ffea_pkg::*; #(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic [SIZE_W-1:0] region_size,
  input  in_item_t          req_item,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output out_item_t         rsp_item
);

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int EW = 2 * ADDR_BITS;
  localparam int LW = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 1;

  // {start, end}, inclusive
  logic [EW-1:0] mem [MAX_EXTENTS];

  logic [EW-1:0]        rd_data;
  logic [IW-1:0]        rd_idx;
  logic                 rd_vld;
  logic [CW-1:0]        ptr;
  logic [CW-1:0]        count;
  logic [CW-1:0]        pos_q;
  logic [SIZE_W-1:0]    size_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [ADDR_BITS-1:0] last_q;
  logic [ADDR_BITS-1:0] prev_start;
  logic [ADDR_BITS-1:0] prev_end;
  logic [IW-1:0]        prev_idx;
  logic                 have_prev;
  logic [FIELD_ADDR_W-1:0] res_granted;
  logic [STATUS_W-1:0]  res_status;

  logic [ADDR_BITS-1:0] rd_start, rd_end;
  logic [ADDR_BITS:0]   len;
  logic [ADDR_BITS-1:0] in_addr;
  logic [LW-1:0]        last_w, top_w, rend_w;
  logic [ADDR_BITS-1:0] init_end;
  logic [CW-1:0]        ptr_m1;
  logic [IW-1:0]        rd_addr;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;

  assign rd_start = rd_data[EW-1:ADDR_BITS];
  assign rd_end   = rd_data[ADDR_BITS-1:0];
  assign len      = (ADDR_BITS+1)'(rd_end) - (ADDR_BITS+1)'(rd_start) + (ADDR_BITS+1)'(1);

  assign in_addr  = ADDR_BITS'(req_item.release_addr);
  assign top_w    = LW'({ADDR_BITS{1'b1}});
  assign last_w   = LW'(in_addr) + LW'(req_item.block_size) - LW'(1);
  assign rend_w   = (region_size == '0) ? '0 : LW'(region_size) - LW'(1);
  assign init_end = (rend_w > top_w) ? {ADDR_BITS{1'b1}} : rend_w[ADDR_BITS-1:0];

  assign ptr_m1  = ptr - CW'(1);
  assign rd_addr = cmd.rd_up ? ptr_m1[IW-1:0] : ptr[IW-1:0];

  always_comb begin
    stat.in_alloc     = (req_item.op == OP_ALLOC);
    stat.in_size_zero = (req_item.block_size == '0);
    stat.count_zero   = (count == '0);
    stat.rd_vld       = rd_vld;
    stat.fwd_more     = (ptr < count);
    stat.up_more      = (ptr > pos_q);
    stat.fits         = (rd_end >= rd_start) && (LW'(len) >= LW'(size_q));
    stat.exact        = (LW'(len) == LW'(size_q));
    stat.above        = (rd_start > addr_q);
    stat.join_prev    = have_prev
                        && ((ADDR_BITS+1)'(prev_end) + (ADDR_BITS+1)'(1)
                            == (ADDR_BITS+1)'(addr_q));
    stat.join_next    = rd_vld && (rd_start > addr_q)
                        && ((ADDR_BITS+1)'(last_q) + (ADDR_BITS+1)'(1)
                            == (ADDR_BITS+1)'(rd_start));
    stat.full         = (count == CW'(MAX_EXTENTS));
    stat.out_free     = !rsp_valid || rsp_ready;
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = rd_idx;
    wr_data = rd_data;
    case (cmd.wr_sel)
      WR_INIT: begin
        wr_addr = '0;
        wr_data = {{ADDR_BITS{1'b0}}, init_end};
      end
      WR_SHRINK: begin
        wr_data = {rd_start + ADDR_BITS'(size_q), rd_end};
      end
      WR_SHIFT_DN: begin
        wr_addr = rd_idx - IW'(1);
      end
      WR_MERGE_BOTH: begin
        wr_addr = prev_idx;
        wr_data = {prev_start, rd_end};
      end
      WR_MERGE_PREV: begin
        wr_addr = prev_idx;
        wr_data = {prev_start, last_q};
      end
      WR_MERGE_NEXT: begin
        wr_data = {addr_q, rd_end};
      end
      WR_SHIFT_UP: begin
        wr_addr = rd_idx + IW'(1);
      end
      WR_INSERT: begin
        wr_addr = pos_q[IW-1:0];
        wr_data = {addr_q, last_q};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
      rd_idx  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      ptr       <= '0;
      count     <= CW'(1);
      have_prev <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      case (cmd.ptr_op)
        PTR_CLR: ptr <= '0;
        PTR_INC: ptr <= ptr + CW'(1);
        PTR_DEC: ptr <= ptr_m1;
        PTR_TOP: ptr <= count;
        default: ptr <= ptr;
      endcase
      if (cfg_wr) begin
        count <= CW'(1);
      end else if (cmd.cnt_op == CNT_INC) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_op == CNT_DEC) begin
        count <= count - CW'(1);
      end
      if (cmd.req_load) begin
        have_prev <= 1'b0;
      end else if (cmd.prev_load) begin
        have_prev <= 1'b1;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      size_q <= req_item.block_size;
      addr_q <= in_addr;
      last_q <= (last_w > top_w) ? {ADDR_BITS{1'b1}} : last_w[ADDR_BITS-1:0];
    end
    if (cmd.prev_load) begin
      prev_start <= rd_start;
      prev_end   <= rd_end;
      prev_idx   <= rd_idx;
    end
    if (cmd.pos_load) begin
      pos_q <= (rd_vld && stat.above) ? CW'(rd_idx) : count;
    end
    if (cmd.res_load) begin
      res_granted <= cmd.res_grant ? FIELD_ADDR_W'(rd_start) : '0;
      res_status  <= cmd.res_status;
    end
    if (cmd.out_load) begin
      rsp_item.granted_addr <= res_granted;
      rsp_item.status       <= res_status;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/first_fit_extent_allocator_top.sv -----
// First-fit extent allocator with coalescing: top level, APB register and
// assertions. Depends on ffea_pkg, ffea_ctrl, ffea_dpath, assert_macros.svh.
//
// Usage:
//   req channel (req_valid/req_ready/req_item) takes one item at a time:
//   allocate (op 0) of block_size units, or release (op 1) of block_size
//   units at release_addr. Each item gives exactly one rsp item
//   (rsp_valid/rsp_ready/rsp_item) with granted_addr and status, unless a
//   region_size write reloads the table before its result is loaded.
//   The scan reads the extents in order from the single extent memory; an
//   exact fit or a merge of both neighbours then moves the following
//   entries down, and an insert moves the entries from its position up.
//   Zero-size requests and allocates on an empty table skip the scan.
//   Reset loads region_size 1000 and one extent; the init state after
//   reset writes that extent while req_ready is low.
//   A write of region_size (address 0) reloads the table via the init state.
//   A stalled rsp holds the item in the output register; the next item
//   may be accepted meanwhile and its result waits for the register.
`default_nettype none

`include "assert_macros.svh"

module first_fit_extent_allocator_top import ffea_pkg::*; #(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  in_item_t              req_item,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output out_item_t             rsp_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [SIZE_W-1:0] region_size;
  logic              cfg_wr;
  cmd_t              cmd;
  stat_t             stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_REGION_SIZE);
  assign prdata = (paddr[2] == REG_REGION_SIZE) ? APB_DATA_W'(region_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_size <= REGION_RESET;
    end else if (cfg_wr) begin
      region_size <= pwdata[SIZE_W-1:0];
    end
  end

  ffea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffea_dpath #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .region_size (region_size),
    .req_item    (req_item),
    .cmd         (cmd),
    .stat        (stat),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp_item    (rsp_item)
  );

  `FFEA_ASSERT_IMP(a_out_slot_free, cmd.out_load, stat.out_free, "result loaded over a waiting item")
  `FFEA_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready, "second item taken while busy")
  `FFEA_ASSERT_IMP(a_nofit_zero, rsp_valid && rsp_item.status == ST_NO_FIT, rsp_item.granted_addr == '0, "no_fit with non-zero address")

endmodule

`default_nettype wire
